/* hdl/iqea_pkg.sv */
`timescale 1ns / 1ps

package iqea_pkg;

    localparam int SUM_W    = 56;
    localparam int LUMA_W   = 16;
    localparam int SQ_W     = 2 * LUMA_W;
    localparam int COUNT_W  = 25;
    localparam int PIX_W    = 8;

    localparam int S_TDATA_W = 6 * PIX_W;
    localparam int M_TDATA_W = 160;
    localparam int M_PAD_W   = M_TDATA_W - (2 * SUM_W + LUMA_W + COUNT_W);

    localparam logic [COUNT_W-1:0] MAX_PIXELS = 25'd16777216;
    localparam logic [SUM_W-1:0]   SUM_MAX    = {SUM_W{1'b1}};
    localparam logic [LUMA_W-1:0]  PEAK_MAX   = 16'd65280;

    // BT.601 weights in Q0.8
    localparam logic [LUMA_W-1:0] W_RED   = 16'd77;
    localparam logic [LUMA_W-1:0] W_GREEN = 16'd150;
    localparam logic [LUMA_W-1:0] W_BLUE  = 16'd29;

    localparam logic MODE_GREY  = 1'b0;
    localparam logic MODE_COLOR = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [LUMA_W-1:0] lo;
        logic [LUMA_W-1:0] lm;
        logic              last;
    } luma_entry_t;

    typedef struct packed {
        logic [COUNT_W-1:0] pixel_count;
        logic [LUMA_W-1:0]  peak_luma;
        logic [SUM_W-1:0]   error_energy;
        logic [SUM_W-1:0]   signal_energy;
    } result_t;

    function automatic logic [LUMA_W-1:0] luma_of(input logic mode,
                                                  input logic [PIX_W-1:0] r,
                                                  input logic [PIX_W-1:0] g,
                                                  input logic [PIX_W-1:0] b);
        logic [LUMA_W-1:0] lum;
        if (mode == MODE_COLOR) begin
            lum = W_RED * {8'd0, r} + W_GREEN * {8'd0, g} + W_BLUE * {8'd0, b};
        end else begin
            lum = {r, 8'd0};
        end
        return lum;
    endfunction

endpackage

/* hdl/image_quality_error_accumulator_unit.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// s_        in         s_tvalid / s_tready   s_tdata (six pixel bytes), s_tlast (last pair)
// m_        out        m_tvalid / m_tready   m_tdata (energies, peak, count)
// cfg_      in         cfg_valid / cfg_ready cfg_data (color_mode)
//
// One pixel pair per clock sustained while s_tready is high; m_tvalid rises once a
// last pair has passed the queue, then the square stage, then the output register.
// Luma is computed at acceptance into a 4-entry queue; the back end squares, then
// accumulates with saturation, and loads the output register on a last pair.
// aresetn is synchronous: clears queue, stages, sums, result valid; color_mode goes to 1.
// A result held by m_tready low stalls the accumulator only on the next last pair;
// s_tready drops once the queue fills behind it.

module image_quality_error_accumulator_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // orig_r, orig_g, orig_b, mod_r, mod_g, mod_b
    input  logic [iqea_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // signal_energy, error_energy, peak_luma, pixel_count, zero pad
    output logic [iqea_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data
);

    iqea_pkg::luma_entry_t front_entry;
    iqea_pkg::luma_entry_t q_entry;
    logic                  q_valid;
    logic                  q_ready;

    iqea_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .entry     (front_entry)
    );

    iqea_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_data  (front_entry),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_entry)
    );

    iqea_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_entry),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* hdl/iqea_front.sv */
`timescale 1ns / 1ps

module iqea_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data,
    input  logic [iqea_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,
    output iqea_pkg::luma_entry_t             entry
);

    logic color_mode_reg;
    logic color_mode_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        color_mode_next = color_mode_reg;
        if (cfg_valid && cfg_ready) begin
            color_mode_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_mode_reg <= iqea_pkg::MODE_COLOR;
        end else begin
            color_mode_reg <= color_mode_next;
        end
    end

    // tdata: orig_r, orig_g, orig_b, mod_r, mod_g, mod_b from the low byte up
    always_comb begin
        entry.lo   = iqea_pkg::luma_of(color_mode_reg, s_tdata[7:0], s_tdata[15:8],
                                       s_tdata[23:16]);
        entry.lm   = iqea_pkg::luma_of(color_mode_reg, s_tdata[31:24], s_tdata[39:32],
                                       s_tdata[47:40]);
        entry.last = s_tlast;
    end

endmodule

/* hdl/iqea_queue.sv */
`timescale 1ns / 1ps

module iqea_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  iqea_pkg::luma_entry_t push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output iqea_pkg::luma_entry_t pop_data
);

    iqea_pkg::luma_entry_t entries_reg [iqea_pkg::QUEUE_DEPTH];

    logic [iqea_pkg::QUEUE_AW-1:0] wr_ptr_reg;
    logic [iqea_pkg::QUEUE_AW-1:0] wr_ptr_next;
    logic [iqea_pkg::QUEUE_AW-1:0] rd_ptr_reg;
    logic [iqea_pkg::QUEUE_AW-1:0] rd_ptr_next;
    logic [iqea_pkg::QUEUE_CW-1:0] fill_reg;
    logic [iqea_pkg::QUEUE_CW-1:0] fill_next;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = (fill_reg != iqea_pkg::QUEUE_CW'(iqea_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/iqea_back.sv */
`timescale 1ns / 1ps

module iqea_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  iqea_pkg::luma_entry_t             q_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [iqea_pkg::M_TDATA_W-1:0]    m_tdata
);

    // square stage
    logic                          sq_valid_reg;
    logic                          sq_valid_next;
    logic [iqea_pkg::SQ_W-1:0]     sq_sig_reg;
    logic [iqea_pkg::SQ_W-1:0]     sq_err_reg;
    logic [iqea_pkg::LUMA_W-1:0]   sq_lo_reg;
    logic                          sq_last_reg;
    logic [iqea_pkg::LUMA_W-1:0]   diff;
    logic                          sq_load;

    // accumulate stage
    logic [iqea_pkg::SUM_W-1:0]    sig_sum_reg;
    logic [iqea_pkg::SUM_W-1:0]    sig_sum_next;
    logic [iqea_pkg::SUM_W-1:0]    err_sum_reg;
    logic [iqea_pkg::SUM_W-1:0]    err_sum_next;
    logic [iqea_pkg::LUMA_W-1:0]   peak_reg;
    logic [iqea_pkg::LUMA_W-1:0]   peak_next;
    logic [iqea_pkg::COUNT_W-1:0]  count_reg;
    logic [iqea_pkg::COUNT_W-1:0]  count_next;
    logic [iqea_pkg::SUM_W:0]      sig_wide;
    logic [iqea_pkg::SUM_W:0]      err_wide;
    logic [iqea_pkg::SUM_W-1:0]    sig_upd;
    logic [iqea_pkg::SUM_W-1:0]    err_upd;
    logic [iqea_pkg::LUMA_W-1:0]   peak_upd;
    logic [iqea_pkg::COUNT_W-1:0]  count_upd;
    logic                          acc_take;

    // output register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    iqea_pkg::result_t             out_reg;

    // a last pair waits here until the output register is free
    assign acc_take = sq_valid_reg && (!sq_last_reg || !out_valid_reg || m_tready);
    assign sq_load  = q_valid && (!sq_valid_reg || acc_take);
    assign q_ready  = sq_load;

    assign diff = (q_data.lo >= q_data.lm) ? (q_data.lo - q_data.lm)
                                           : (q_data.lm - q_data.lo);

    always_comb begin
        sq_valid_next = sq_valid_reg;
        if (sq_load) begin
            sq_valid_next = 1'b1;
        end else if (acc_take) begin
            sq_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
        end else begin
            sq_valid_reg <= sq_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (sq_load) begin
            sq_sig_reg  <= iqea_pkg::SQ_W'(q_data.lo) * iqea_pkg::SQ_W'(q_data.lo);
            sq_err_reg  <= iqea_pkg::SQ_W'(diff) * iqea_pkg::SQ_W'(diff);
            sq_lo_reg   <= q_data.lo;
            sq_last_reg <= q_data.last;
        end
    end

    // saturate when the sum carries past the top bit
    always_comb begin
        sig_wide  = {1'b0, sig_sum_reg} + (iqea_pkg::SUM_W + 1)'(sq_sig_reg);
        err_wide  = {1'b0, err_sum_reg} + (iqea_pkg::SUM_W + 1)'(sq_err_reg);
        sig_upd   = sig_wide[iqea_pkg::SUM_W] ? iqea_pkg::SUM_MAX
                                              : sig_wide[iqea_pkg::SUM_W-1:0];
        err_upd   = err_wide[iqea_pkg::SUM_W] ? iqea_pkg::SUM_MAX
                                              : err_wide[iqea_pkg::SUM_W-1:0];
        peak_upd  = (sq_lo_reg > peak_reg) ? sq_lo_reg : peak_reg;
        count_upd = (count_reg < iqea_pkg::MAX_PIXELS) ? (count_reg + 1'b1) : count_reg;
    end

    always_comb begin
        sig_sum_next   = sig_sum_reg;
        err_sum_next   = err_sum_reg;
        peak_next      = peak_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (acc_take) begin
            if (sq_last_reg) begin
                sig_sum_next   = '0;
                err_sum_next   = '0;
                peak_next      = '0;
                count_next     = '0;
                out_valid_next = 1'b1;
            end else begin
                sig_sum_next = sig_upd;
                err_sum_next = err_upd;
                peak_next    = peak_upd;
                count_next   = count_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_sum_reg   <= '0;
            err_sum_reg   <= '0;
            peak_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            sig_sum_reg   <= sig_sum_next;
            err_sum_reg   <= err_sum_next;
            peak_reg      <= peak_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_take && sq_last_reg) begin
            out_reg.signal_energy <= sig_upd;
            out_reg.error_energy  <= err_upd;
            out_reg.peak_luma     <= peak_upd;
            out_reg.pixel_count   <= count_upd;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{iqea_pkg::M_PAD_W{1'b0}}, out_reg};

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_take && sq_last_reg) |=> (count_reg == '0 && sig_sum_reg == '0))
        else $error("accumulators not cleared after last pair");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= iqea_pkg::MAX_PIXELS)
        else $error("pixel count beyond limit");

    a_peak_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        peak_reg <= iqea_pkg::PEAK_MAX)
        else $error("peak luma out of range");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> ($stable(out_reg) && out_valid_reg))
        else $error("pending result overwritten");
`endif

endmodule

/* tb/sv/image_quality_error_accumulator_unit_tb.sv */
`timescale 1ns / 1ps

module image_quality_error_accumulator_unit_tb;

    localparam int unsigned CLK_HALF     = 6;
    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned RANDOM_PAIRS = 950;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    // BT.601 weights, Q0.8
    localparam int unsigned WEIGHT_R = 77;
    localparam int unsigned WEIGHT_G = 150;
    localparam int unsigned WEIGHT_B = 29;

    localparam logic [55:0] ENERGY_CAP = {56{1'b1}};
    localparam logic [24:0] PIXEL_CAP  = 25'd16777216;
    localparam logic [63:0] FULL_SQ    = 64'd4261478400;
    localparam logic [15:0] FULL_LUMA  = 16'd65280;

    typedef iqea_pkg::result_t image_stats_t;

    typedef struct {
        logic         mode;
        logic [47:0]  pair;
        logic         last;
        bit           typed;
        image_stats_t want;
    } pair_row_t;

    logic                               aclk;
    logic                               aresetn   = 1'b0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    // orig_r, orig_g, orig_b, mod_r, mod_g, mod_b
    logic [iqea_pkg::S_TDATA_W-1:0]     s_tdata   = '0;
    logic                               s_tlast   = 1'b0;
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    // signal_energy, error_energy, peak_luma, pixel_count, zero pad
    logic [iqea_pkg::M_TDATA_W-1:0]     m_tdata;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic                               cfg_data  = 1'b0;

    // predictor state
    logic         color_now   = iqea_pkg::MODE_COLOR;
    logic [55:0]  signal_acc  = '0;
    logic [55:0]  error_acc   = '0;
    logic [15:0]  peak_acc    = '0;
    logic [24:0]  count_acc   = '0;
    image_stats_t stats_q[$];

    pair_row_t    rows[$];
    int           errors      = 0;
    int           cycle_count = 0;
    bit           tx_calm     = 1'b0;
    bit           rx_calm     = 1'b0;

    image_quality_error_accumulator_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("image_quality_error_accumulator_unit_tb: done, errors");
            $finish;
        end
    end

    function automatic logic [47:0] pack_pair(input logic [7:0] o_r, o_g, o_b,
                                              input logic [7:0] m_r, m_g, m_b);
        return {m_b, m_g, m_r, o_b, o_g, o_r};
    endfunction

    function automatic logic [15:0] luma_q88(input logic color,
                                             input logic [7:0] r, g, b);
        int unsigned acc;
        if (color == iqea_pkg::MODE_COLOR) begin
            acc = WEIGHT_R * r + WEIGHT_G * g + WEIGHT_B * b;
        end else begin
            acc = {r, 8'd0};
        end
        return acc[15:0];
    endfunction

    function automatic logic [55:0] energy_add(input logic [55:0] acc,
                                               input logic [31:0] term);
        logic [56:0] sum;
        sum = {1'b0, acc} + {25'd0, term};
        return (sum > {1'b0, ENERGY_CAP}) ? ENERGY_CAP : sum[55:0];
    endfunction

    // Both caps sit at or past 2^24 pairs; keep them modeled all the same.
    task automatic accumulate_pair(input logic [47:0] pair, input logic last);
        logic [15:0]  lo;
        logic [15:0]  lm;
        logic [15:0]  diff;
        image_stats_t done;
        lo   = luma_q88(color_now, pair[7:0], pair[15:8], pair[23:16]);
        lm   = luma_q88(color_now, pair[31:24], pair[39:32], pair[47:40]);
        diff = (lo >= lm) ? (lo - lm) : (lm - lo);
        signal_acc = energy_add(signal_acc, 32'(lo) * 32'(lo));
        error_acc  = energy_add(error_acc, 32'(diff) * 32'(diff));
        if (lo > peak_acc) peak_acc = lo;
        if (count_acc < PIXEL_CAP) count_acc = count_acc + 1'b1;
        if (last) begin
            done.signal_energy = signal_acc;
            done.error_energy  = error_acc;
            done.peak_luma     = peak_acc;
            done.pixel_count   = count_acc;
            stats_q.push_back(done);
            signal_acc = '0;
            error_acc  = '0;
            peak_acc   = '0;
            count_acc  = '0;
        end
    endtask

    function automatic logic [47:0] rand_pair();
        logic [7:0] chan[6];
        for (int i = 0; i < 6; i++) begin
            case ($urandom_range(0, 9))
                0:       chan[i] = 8'h00;
                1:       chan[i] = 8'hff;
                default: chan[i] = 8'($urandom_range(0, 255));
            endcase
        end
        // identical pair: zero error term
        if ($urandom_range(0, 5) == 0) begin
            for (int i = 3; i < 6; i++) chan[i] = chan[i-3];
        end
        return pack_pair(chan[0], chan[1], chan[2], chan[3], chan[4], chan[5]);
    endfunction

    // Hold tvalid across back-to-back requests; lower it only for a gap.
    task automatic send_pair(input logic [47:0] pair, input logic last);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pair;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        accumulate_pair(pair, last);
    endtask

    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (stats_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        color_now = mode;
    endtask

    task automatic add_row(input logic mode, input logic [7:0] o_r, o_g, o_b,
                           input logic [7:0] m_r, m_g, m_b, input logic last,
                           input bit typed, input logic [63:0] sig, err,
                           input logic [15:0] peak, input logic [24:0] cnt);
        pair_row_t row;
        row.mode                = mode;
        row.pair                = pack_pair(o_r, o_g, o_b, m_r, m_g, m_b);
        row.last                = last;
        row.typed               = typed;
        row.want.signal_energy  = sig[55:0];
        row.want.error_energy   = err[55:0];
        row.want.peak_luma      = peak;
        row.want.pixel_count    = cnt;
        rows.push_back(row);
    endtask

    function automatic void note_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        errors++;
        if (errors <= 10) begin
            $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endfunction

    task automatic check_result(input logic [iqea_pkg::M_TDATA_W-1:0] word);
        image_stats_t got;
        image_stats_t want;
        got = word[$bits(image_stats_t)-1:0];
        if (word[iqea_pkg::M_TDATA_W-1 -: iqea_pkg::M_PAD_W] != '0) begin
            note_mismatch("padding", 0, 64'(word[iqea_pkg::M_TDATA_W-1 -: iqea_pkg::M_PAD_W]));
        end
        if (stats_q.size() == 0) begin
            note_mismatch("unrequested result, pixel_count", 0, 64'(got.pixel_count));
            return;
        end
        want = stats_q.pop_front();
        if (got.signal_energy !== want.signal_energy)
            note_mismatch("signal_energy", 64'(want.signal_energy), 64'(got.signal_energy));
        if (got.error_energy !== want.error_energy)
            note_mismatch("error_energy", 64'(want.error_energy), 64'(got.error_energy));
        if (got.peak_luma !== want.peak_luma)
            note_mismatch("peak_luma", 64'(want.peak_luma), 64'(got.peak_luma));
        if (got.pixel_count !== want.pixel_count)
            note_mismatch("pixel_count", 64'(want.pixel_count), 64'(got.pixel_count));
    endtask

    // Result side: the stall drawn after each accepted result only runs down while a result waits.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                check_result(m_tdata);
                if ($urandom_range(0, 7) == 0) rx_calm = !rx_calm;
                stall = rx_calm ? 0 : $urandom_range(0, 7);
            end else if (m_tvalid && stall > 0) begin
                stall--;
            end
            m_tready <= (stall == 0);
        end
    end

    initial begin
        int sent;
        int pick;
        int len;
        sent = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // color rows: black pair after reset, full swing both ways, weight isolation
        add_row(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 0, 0, 0, 1);
        add_row(1'b1, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1,
                FULL_SQ, FULL_SQ, FULL_LUMA, 1);
        add_row(1'b1, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1,
                0, FULL_SQ, 0, 1);
        add_row(1'b1, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 0, 0, 0, 0);
        add_row(1'b1, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'hff, 1'b1, 1'b0, 0, 0, 0, 0);
        add_row(1'b1, 8'h00, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 1'b1, 1'b0, 0, 0, 0, 0);
        add_row(1'b1, 8'h12, 8'h34, 8'h56, 8'h12, 8'h34, 8'h56, 1'b0, 1'b0, 0, 0, 0, 0);
        add_row(1'b1, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 1'b0, 1'b0, 0, 0, 0, 0);
        add_row(1'b1, 8'h80, 8'h7f, 8'h01, 8'hfe, 8'h01, 8'h80, 1'b1, 1'b0, 0, 0, 0, 0);
        // grey rows: only red counts
        add_row(1'b0, 8'hff, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 1'b1, 1'b1,
                FULL_SQ, FULL_SQ, FULL_LUMA, 1);
        add_row(1'b0, 8'h00, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 0, 0, 0, 1);
        add_row(1'b0, 8'h80, 8'h11, 8'h22, 8'h7f, 8'h33, 8'h44, 1'b0, 1'b0, 0, 0, 0, 0);
        add_row(1'b0, 8'h01, 8'hff, 8'hff, 8'hfe, 8'h00, 8'h00, 1'b0, 1'b0, 0, 0, 0, 0);
        // switch modes inside one image
        add_row(1'b1, 8'hc3, 8'h3c, 8'h5a, 8'h5a, 8'hc3, 8'h3c, 1'b0, 1'b0, 0, 0, 0, 0);
        add_row(1'b1, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hfe, 1'b0, 1'b0, 0, 0, 0, 0);
        add_row(1'b0, 8'h40, 8'h00, 8'h00, 8'hc0, 8'h00, 8'h00, 1'b1, 1'b0, 0, 0, 0, 0);
        add_row(1'b1, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 1'b1, 1'b0, 0, 0, 0, 0);

        foreach (rows[i]) begin
            if (rows[i].mode != color_now) begin
                settle_idle();
                write_mode(rows[i].mode);
            end
            send_pair(rows[i].pair, rows[i].last);
            if (rows[i].typed) stats_q[stats_q.size()-1] = rows[i].want;
        end

        // mostly short images, a few long ones
        while (sent < RANDOM_PAIRS) begin
            pick = $urandom_range(0, 9);
            len  = (pick < 6) ? $urandom_range(1, 8) :
                   (pick < 9) ? $urandom_range(9, 30) : $urandom_range(31, 80);
            if ($urandom_range(0, 7) == 0) begin
                settle_idle();
                write_mode(1'($urandom_range(0, 1)));
            end
            for (int k = 0; k < len; k++) begin
                if (k > 0 && $urandom_range(0, 99) == 0) begin
                    settle_idle();
                    write_mode(!color_now);
                end
                send_pair(rand_pair(), k == len - 1);
                sent++;
            end
        end

        settle_idle();
        if (errors == 0) begin
            $display("image_quality_error_accumulator_unit_tb: done, clean");
        end else begin
            $display("image_quality_error_accumulator_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/iqea_pkg.sv
hdl/iqea_front.sv
hdl/iqea_queue.sv
hdl/iqea_back.sv
hdl/image_quality_error_accumulator_unit.sv
tb/sv/image_quality_error_accumulator_unit_tb.sv
